// ===== rtl/c2aa_pkg.sv =====
// Shared types and constants of the codon to amino acid translator.
package c2aa_pkg;

  localparam logic [7:0] StopSymbolReset = 8'h2A;  // '*'
  localparam logic [7:0] CharUnknown     = "X";
  localparam logic [1:0] FrameMax        = 2'd2;

  typedef enum logic [1:0] {
    CfgFrameOffset = 2'd0,
    CfgHaltOnStop  = 2'd1,
    CfgStopSymbol  = 2'd2
  } cfg_reg_e;

  // Complete codon handed from the framer to the lookup.
  typedef struct packed {
    logic       vld;
    logic [7:0] first;
    logic [7:0] second;
    logic [7:0] third;
  } codon_t;

  // Lookup answer for one codon.
  typedef struct packed {
    logic       emit;
    logic       stop;
    logic [7:0] letter;
  } xlate_t;

endpackage

// ===== rtl/c2aa_lookup.sv =====
// Standard genetic code lookup with IUPAC ambiguity letters.
module c2aa_lookup
  import c2aa_pkg::*;
(
  input  codon_t codon_i,
  output xlate_t xlate_o
);

  function automatic logic is_iupac(input logic [7:0] ch);
    logic ok;
    case (ch)
      "A", "B", "C", "D", "G", "H", "K", "M", "N",
      "R", "S", "T", "U", "V", "W", "X", "Y": ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [7:0] fold_u(input logic [7:0] ch);
    return (ch == "U") ? 8'("T") : ch;
  endfunction

  function automatic logic pyr3(input logic [7:0] ch);
    return (ch == "C") || (ch == "T") || (ch == "Y");
  endfunction

  function automatic logic pur3(input logic [7:0] ch);
    return (ch == "A") || (ch == "G") || (ch == "R");
  endfunction

  function automatic logic ile3(input logic [7:0] ch);
    return (ch == "A") || (ch == "C") || (ch == "T") || (ch == "M") ||
           (ch == "W") || (ch == "Y") || (ch == "H");
  endfunction

  logic [7:0] a, b, c;
  logic       stop;
  logic [7:0] letter;

  always_comb begin
    a      = fold_u(codon_i.first);
    b      = fold_u(codon_i.second);
    c      = fold_u(codon_i.third);
    stop   = 1'b0;
    letter = CharUnknown;
    case (a)
      "T": begin
        if (b == "C") begin
          letter = "S";
        end else if (b == "T") begin
          if (pyr3(c)) letter = "F";
          else if (pur3(c)) letter = "L";
        end else if (b == "A") begin
          if (pyr3(c)) letter = "Y";
          else if (pur3(c)) stop = 1'b1;
        end else if (b == "G") begin
          if (pyr3(c)) letter = "C";
          else if (c == "A") stop = 1'b1;
          else if (c == "G") letter = "W";
        end else if (b == "R" && c == "A") begin
          stop = 1'b1;
        end
      end
      "C": begin
        if (b == "T") letter = "L";
        else if (b == "C") letter = "P";
        else if (b == "A") begin
          if (pyr3(c)) letter = "H";
          else if (pur3(c)) letter = "Q";
        end else if (b == "G") letter = "R";
      end
      "Y": begin
        if (b == "T" && pur3(c)) letter = "L";
      end
      "A": begin
        if (b == "T") begin
          if (ile3(c)) letter = "I";
          else if (c == "G") letter = "M";
        end else if (b == "C") letter = "T";
        else if (b == "A") begin
          if (pyr3(c)) letter = "N";
          else if (pur3(c)) letter = "K";
        end else if (b == "G") begin
          if (pyr3(c)) letter = "S";
          else if (pur3(c)) letter = "R";
        end
      end
      "M": begin
        if (b == "G" && pur3(c)) letter = "R";
      end
      "G": begin
        if (b == "T") letter = "V";
        else if (b == "C") letter = "A";
        else if (b == "A") begin
          if (pyr3(c)) letter = "D";
          else if (pur3(c)) letter = "E";
        end else if (b == "G") letter = "G";
      end
      default: letter = CharUnknown;
    endcase
  end

  // Drop codons that hold a non-IUPAC character.
  assign xlate_o.emit   = codon_i.vld && is_iupac(codon_i.first) &&
                          is_iupac(codon_i.second) && is_iupac(codon_i.third);
  assign xlate_o.stop   = stop;
  assign xlate_o.letter = letter;

endmodule

// ===== rtl/c2aa_framer.sv =====
// Frame skipping, codon gathering and halt tracking.
module c2aa_framer
  import c2aa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] base_i,
  input  logic       start_i,
  input  logic [1:0] frame_offset_i,
  input  logic       halt_on_stop_i,
  input  logic       stop_i,
  output codon_t     codon_o
);

  logic [1:0] skip_q, skip_d;
  logic [1:0] pos_q, pos_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;
  logic       halted_q, halted_d;

  logic [1:0] skip_eff, pos_eff, frame;
  logic       halted_eff, in_codon, codon_vld;

  assign skip_eff   = start_i ? 2'd0 : skip_q;
  assign pos_eff    = start_i ? 2'd0 : pos_q;
  assign halted_eff = start_i ? 1'b0 : halted_q;
  assign frame      = (frame_offset_i > FrameMax) ? FrameMax : frame_offset_i;
  assign in_codon   = !halted_eff && (skip_eff >= frame);
  assign codon_vld  = in_codon && (pos_eff == 2'd2);

  always_comb begin
    skip_d   = skip_eff;
    pos_d    = pos_eff;
    first_d  = first_q;
    second_d = second_q;
    halted_d = halted_eff;
    if (!halted_eff && !in_codon) begin
      skip_d = skip_eff + 2'd1;
    end else if (in_codon) begin
      case (pos_eff)
        2'd0: begin
          first_d = base_i;
          pos_d   = 2'd1;
        end
        2'd1: begin
          second_d = base_i;
          pos_d    = 2'd2;
        end
        default: begin
          pos_d = 2'd0;
          if (stop_i && halt_on_stop_i) halted_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q   <= '0;
      pos_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      halted_q <= 1'b0;
    end else if (advance_i) begin
      skip_q   <= skip_d;
      pos_q    <= pos_d;
      first_q  <= first_d;
      second_q <= second_d;
      halted_q <= halted_d;
    end
  end

  assign codon_o.vld    = codon_vld;
  assign codon_o.first  = first_q;
  assign codon_o.second = second_q;
  assign codon_o.third  = base_i;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q != 2'd3)
    else $error("codon position out of range");

  a_skip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q <= FrameMax)
    else $error("skip count beyond frame limit");

  a_halt_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(halted_q) |-> $past(advance_i && codon_vld && stop_i && halt_on_stop_i))
    else $error("halt set without a stop codon");

endmodule

// ===== rtl/codon_to_amino_acid_translator_top.sv =====
// Top level of the codon to amino acid translator.
// A request is taken into the input register, and its result is
//   registered in the output register once that is empty or being drained.
// Throughput: one base per cycle; the framer and lookup sit between the
//   input register and the output register. A held result stalls the input.
// Reset: rst_ni clears all valids, codon state and halt; registers return
//   to frame 0, halting off and stop symbol '*'.
module codon_to_amino_acid_translator_top
  import c2aa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // Base requests
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] base_char_i,
  input  logic       seq_start_i,
  // Amino acid results
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] amino_char_o,
  output logic       is_stop_o
);

  // Configuration registers; writes are always taken.
  logic [1:0] frame_offset_q;
  logic       halt_on_stop_q;
  logic [7:0] stop_symbol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_offset_q <= 2'd0;
      halt_on_stop_q <= 1'b0;
      stop_symbol_q  <= StopSymbolReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CfgFrameOffset: frame_offset_q <= cfg_data_i[1:0];
        CfgHaltOnStop:  halt_on_stop_q <= cfg_data_i[0];
        CfgStopSymbol:  stop_symbol_q  <= cfg_data_i;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // Input register: hold one request until the output side has room.
  logic       in_vld_q;
  logic [7:0] in_base_q;
  logic       in_start_q;
  logic       advance;

  assign advance    = in_vld_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_base_q  <= base_char_i;
      in_start_q <= seq_start_i;
    end
  end

  // Framer and lookup: all work for one base in a single pass.
  codon_t codon;
  xlate_t xlate;

  c2aa_framer u_framer (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .base_i         (in_base_q),
    .start_i        (in_start_q),
    .frame_offset_i (frame_offset_q),
    .halt_on_stop_i (halt_on_stop_q),
    .stop_i         (xlate.stop),
    .codon_o        (codon)
  );

  c2aa_lookup u_lookup (
    .codon_i (codon),
    .xlate_o (xlate)
  );

  // Output register: advance only when empty or being drained.
  logic       out_vld_q;
  logic [7:0] out_amino_q;
  logic       out_stop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= xlate.emit;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && xlate.emit) begin
      out_amino_q <= xlate.stop ? stop_symbol_q : xlate.letter;
      out_stop_q  <= xlate.stop;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign amino_char_o = out_amino_q;
  assign is_stop_o    = out_stop_q;

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(advance && xlate.emit))
    else $error("result appeared without a finished codon");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_base_q))
    else $error("stalled request lost from input register");

endmodule

// ===== sim/codon_to_amino_acid_translator_top_test.sv =====
// Self-checking testbench for the codon to amino acid translator top level.
`timescale 1ns / 1ps

module codon_to_amino_acid_translator_top_test;
  import c2aa_pkg::*;

  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned DrainCycles   = 4;    // two pipeline stages plus margin
  localparam int unsigned PhaseBases    = 125;
  localparam int unsigned RandomPhases  = 7;
  localparam int unsigned IdlePercent   = 29;
  localparam int unsigned CalmFrom      = 300;
  localparam int unsigned CalmTo        = 450;
  localparam int unsigned SqueezeAt     = 650;
  localparam int unsigned SqueezeCycles = 300;

  // How a table row is handled: predicted, typed as silent, typed with a
  // result, or a register write.
  typedef enum logic [1:0] {
    StepPredict,
    StepQuiet,
    StepEmit,
    StepWrite
  } step_e;

  typedef struct {
    step_e      kind;
    cfg_reg_e   sel;
    logic [7:0] data;
    logic       start;
    logic [7:0] want_char;
    logic       want_stop;
  } plan_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] base_char_i;
  logic       seq_start_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] amino_char_o;
  logic       is_stop_o;

  codon_to_amino_acid_translator_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .base_char_i  (base_char_i),
    .seq_start_i  (seq_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .amino_char_o (amino_char_o),
    .is_stop_o    (is_stop_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the registers and of the framing state.
  logic [1:0] frame_cfg;
  logic       halt_cfg;
  logic [7:0] stop_cfg;
  logic [1:0] skip_cnt;
  logic [1:0] codon_pos;
  logic [7:0] held_first;
  logic [7:0] held_second;
  logic       halted_seq;

  // Amino acids owed by the block, oldest first.
  xlate_t      pending_aminos[$];
  plan_row_t   plan[$];

  int unsigned bases_taken  = 0;
  int unsigned aminos_seen  = 0;
  int unsigned stops_seen   = 0;
  int unsigned reg_writes   = 0;
  int unsigned failures     = 0;
  int unsigned cycles       = 0;
  logic        squeezed     = 1'b0;

  string plain_bases   = "ACGTU";
  string iupac_letters = "ABCDGHKMNRSTUVWXY";

  // Both sides stop idling for a while so back-to-back traffic is seen too.
  logic calm;
  assign calm = (bases_taken >= CalmFrom) && (bases_taken < CalmTo);

  function automatic logic is_iupac(input logic [7:0] c);
    case (c)
      "A", "B", "C", "D", "G", "H", "K", "M", "N",
      "R", "S", "T", "U", "V", "W", "X", "Y": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] fold_u(input logic [7:0] c);
    return (c == "U") ? "T" : c;
  endfunction

  function automatic logic is_pyr(input logic [7:0] c);
    return (c == "C") || (c == "T") || (c == "Y");
  endfunction

  function automatic logic is_pur(input logic [7:0] c);
    return (c == "A") || (c == "G") || (c == "R");
  endfunction

  // Twofold site: pyrimidine picks the first letter, purine the second.
  function automatic logic [7:0] pick_pair(input logic [7:0] c, input logic [7:0] pyr_aa,
                                           input logic [7:0] pur_aa);
    if (is_pyr(c)) return pyr_aa;
    if (is_pur(c)) return pur_aa;
    return CharUnknown;
  endfunction

  // Standard code on folded IUPAC letters; anything not listed is unknown.
  function automatic xlate_t decode_codon(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c);
    xlate_t r;
    r.emit   = 1'b1;
    r.stop   = 1'b0;
    r.letter = CharUnknown;
    case (a)
      "T": begin
        if (b == "C") r.letter = "S";
        else if (b == "T") r.letter = pick_pair(c, "F", "L");
        else if (b == "A" && is_pur(c)) r.stop = 1'b1;
        else if (b == "A") r.letter = pick_pair(c, "Y", CharUnknown);
        else if (b == "G" && c == "A") r.stop = 1'b1;
        else if (b == "G" && c == "G") r.letter = "W";
        else if (b == "G") r.letter = pick_pair(c, "C", CharUnknown);
        else if (b == "R" && c == "A") r.stop = 1'b1;
      end
      "C": begin
        case (b)
          "T": r.letter = "L";
          "C": r.letter = "P";
          "A": r.letter = pick_pair(c, "H", "Q");
          "G": r.letter = "R";
          default: ;
        endcase
      end
      "Y": begin
        if (b == "T" && is_pur(c)) r.letter = "L";
      end
      "A": begin
        if (b == "T") begin
          case (c)
            "A", "C", "T", "M", "W", "Y", "H": r.letter = "I";
            "G": r.letter = "M";
            default: ;
          endcase
        end else if (b == "C") r.letter = "T";
        else if (b == "A") r.letter = pick_pair(c, "N", "K");
        else if (b == "G") r.letter = pick_pair(c, "S", "R");
      end
      "M": begin
        if (b == "G" && is_pur(c)) r.letter = "R";
      end
      "G": begin
        case (b)
          "T": r.letter = "V";
          "C": r.letter = "A";
          "A": r.letter = pick_pair(c, "D", "E");
          "G": r.letter = "G";
          default: ;
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  // Advance the shadow framer by one base; emit is set when a result is owed.
  function automatic xlate_t translate_base(input logic [7:0] base, input logic start);
    xlate_t     r;
    logic [1:0] frame;
    r = '0;
    if (start) begin
      skip_cnt   = 2'd0;
      codon_pos  = 2'd0;
      halted_seq = 1'b0;
    end
    if (halted_seq) return r;
    // A frame offset of three behaves as two.
    frame = (frame_cfg > FrameMax) ? FrameMax : frame_cfg;
    if (skip_cnt < frame) begin
      skip_cnt++;
      return r;
    end
    if (codon_pos == 2'd0) begin
      held_first = base;
      codon_pos  = 2'd1;
      return r;
    end
    if (codon_pos == 2'd1) begin
      held_second = base;
      codon_pos   = 2'd2;
      return r;
    end
    codon_pos = 2'd0;
    // A foreign character anywhere in the codon silences it.
    if (!is_iupac(held_first) || !is_iupac(held_second) || !is_iupac(base)) return r;
    r = decode_codon(fold_u(held_first), fold_u(held_second), fold_u(base));
    if (r.stop) begin
      r.letter = stop_cfg;
      if (halt_cfg) halted_seq = 1'b1;
    end
    return r;
  endfunction

  function automatic logic [7:0] pick_base();
    int unsigned roll;
    logic [7:0]  c;
    roll = $urandom_range(0, 99);
    if (roll < 8) c = 8'($urandom_range(0, 255));
    else if (roll < 70) c = plain_bases[$urandom_range(0, 4)];
    else c = iupac_letters[$urandom_range(0, 16)];
    return c;
  endfunction

  task automatic send_row(input step_e kind, input logic [7:0] base, input logic start,
                          input logic [7:0] want_char, input logic want_stop);
    plan_row_t r;
    r.kind      = kind;
    r.sel       = CfgFrameOffset;
    r.data      = base;
    r.start     = start;
    r.want_char = want_char;
    r.want_stop = want_stop;
    plan.push_back(r);
  endtask

  task automatic write_row(input cfg_reg_e sel, input logic [7:0] data);
    plan_row_t r;
    r.kind      = StepWrite;
    r.sel       = sel;
    r.data      = data;
    r.start     = 1'b0;
    r.want_char = 8'h00;
    r.want_stop = 1'b0;
    plan.push_back(r);
  endtask

  // Offer one base request. Enter and leave at a falling edge with nothing
  // yet scheduled on the request signals in that step.
  task automatic offer_base(input plan_row_t r);
    xlate_t got;
    xlate_t want;
    // Idle at random before raising valid.
    while (!calm && ($urandom_range(0, 99) < IdlePercent)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    base_char_i <= r.data;
    seq_start_i <= r.start;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    // Request taken at this edge: advance the shadow framer.
    got = translate_base(r.data, r.start);
    bases_taken++;
    case (r.kind)
      StepPredict: begin
        if (got.emit) pending_aminos.push_back(got);
      end
      StepEmit: begin
        want.emit   = 1'b1;
        want.stop   = r.want_stop;
        want.letter = r.want_char;
        pending_aminos.push_back(want);
      end
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  // Drop valid and wait until the block has gone quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_aminos.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e sel, input logic [7:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (sel)
      CfgFrameOffset: frame_cfg = data[1:0];
      CfgHaltOnStop:  halt_cfg  = data[0];
      CfgStopSymbol:  stop_cfg  = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Result side: random back-pressure, plus one long hold-off once the run
  // is well under way so the pipeline fills and stalls its input.
  initial begin : result_sink
    int unsigned hold;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!squeezed && (bases_taken >= SqueezeAt)) begin
        squeezed = 1'b1;
        out_ready_i <= 1'b0;
        for (hold = 0; hold < SqueezeCycles; hold++) @(negedge clk_i);
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= IdlePercent);
      end
    end
  end

  // Sample results at the rising edge and match them against the oldest
  // owed amino acid; also guard the run length.
  always @(posedge clk_i) begin : result_check
    xlate_t want;
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_aminos.size() == 0) begin
        failures++;
        $error("amino_char: no result expected, got %h (is_stop %b)", amino_char_o, is_stop_o);
      end else begin
        want = pending_aminos.pop_front();
        aminos_seen++;
        if (is_stop_o === 1'b1) stops_seen++;
        if (amino_char_o !== want.letter) begin
          failures++;
          $error("amino_char: expected %h, got %h", want.letter, amino_char_o);
        end
        if (is_stop_o !== want.stop) begin
          failures++;
          $error("is_stop: expected %b, got %b", want.stop, is_stop_o);
        end
      end
    end
  end

  initial begin : stimulus
    plan_row_t   r;
    int unsigned phase;
    int unsigned k;
    int unsigned seq_len;
    int unsigned phase_first;
    logic [7:0]  f_data;
    logic [7:0]  h_data;
    logic [7:0]  s_data;

    // Hold every input at a known value from time zero.
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgFrameOffset;
    cfg_data_i  = 8'h00;
    in_valid_i  = 1'b0;
    base_char_i = 8'h00;
    seq_start_i = 1'b0;

    // Shadow state after reset.
    frame_cfg   = 2'd0;
    halt_cfg    = 1'b0;
    stop_cfg    = StopSymbolReset;
    skip_cnt    = 2'd0;
    codon_pos   = 2'd0;
    held_first  = 8'h00;
    held_second = 8'h00;
    halted_seq  = 1'b0;

    // Directed table, reset registers first: frame 0, no halting, '*'.
    send_row(StepQuiet,   "A",   1'b1, 8'h00, 1'b0);
    send_row(StepQuiet,   "T",   1'b0, 8'h00, 1'b0);
    send_row(StepEmit,    "G",   1'b0, "M",   1'b0);
    // U reads as T; TRA is an ambiguous stop.
    send_row(StepQuiet,   "U",   1'b0, 8'h00, 1'b0);
    send_row(StepQuiet,   "R",   1'b0, 8'h00, 1'b0);
    send_row(StepEmit,    "A",   1'b0, "*",   1'b1);
    // Foreign bytes at both extremes and a lower case letter: codon is silent.
    send_row(StepQuiet,   8'h00, 1'b0, 8'h00, 1'b0);
    send_row(StepQuiet,   "c",   1'b0, 8'h00, 1'b0);
    send_row(StepQuiet,   8'hFF, 1'b0, 8'h00, 1'b0);
    // A new sequence drops the partial GC codon.
    send_row(StepQuiet,   "G",   1'b1, 8'h00, 1'b0);
    send_row(StepQuiet,   "C",   1'b0, 8'h00, 1'b0);
    send_row(StepQuiet,   "Y",   1'b1, 8'h00, 1'b0);
    send_row(StepQuiet,   "T",   1'b0, 8'h00, 1'b0);
    send_row(StepPredict, "R",   1'b0, 8'h00, 1'b0);
    // Frame three skips two bases; halting on; stop symbol is a letter.
    write_row(CfgFrameOffset, 8'd3);
    write_row(CfgHaltOnStop,  8'd1);
    write_row(CfgStopSymbol,  "W");
    send_row(StepQuiet,   "T",   1'b1, 8'h00, 1'b0);
    send_row(StepQuiet,   "G",   1'b0, 8'h00, 1'b0);
    send_row(StepQuiet,   "T",   1'b0, 8'h00, 1'b0);
    send_row(StepQuiet,   "G",   1'b0, 8'h00, 1'b0);
    send_row(StepEmit,    "G",   1'b0, "W",   1'b0);
    send_row(StepQuiet,   "T",   1'b0, 8'h00, 1'b0);
    send_row(StepQuiet,   "A",   1'b0, 8'h00, 1'b0);
    send_row(StepEmit,    "G",   1'b0, "W",   1'b1);
    // Clearing halting does not release a halted sequence.
    write_row(CfgHaltOnStop,  8'd0);
    write_row(CfgFrameOffset, 8'd0);
    send_row(StepQuiet,   "T",   1'b0, 8'h00, 1'b0);
    send_row(StepQuiet,   "G",   1'b0, 8'h00, 1'b0);
    send_row(StepQuiet,   "G",   1'b0, 8'h00, 1'b0);
    send_row(StepQuiet,   "A",   1'b1, 8'h00, 1'b0);
    send_row(StepQuiet,   "A",   1'b0, 8'h00, 1'b0);
    send_row(StepPredict, "G",   1'b0, 8'h00, 1'b0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == StepWrite) begin
        settle();
        write_reg(plan[i].sel, plan[i].data);
      end else begin
        offer_base(plan[i]);
      end
    end

    // Random sequences, one register setting per phase.
    r.kind      = StepPredict;
    r.sel       = CfgFrameOffset;
    r.want_char = 8'h00;
    r.want_stop = 1'b0;
    for (phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0: begin
          f_data = 8'd0;
          h_data = 8'd0;
          s_data = 8'h00;
        end
        1: begin
          f_data = 8'd3;
          h_data = 8'd1;
          s_data = 8'hFF;
        end
        2: begin
          f_data = 8'd1;
          h_data = 8'd1;
          s_data = StopSymbolReset;
        end
        default: begin
          // Upper bits of the narrow registers are don't-care; toggle them.
          f_data = 8'($urandom_range(0, 255));
          h_data = 8'($urandom_range(0, 255));
          s_data = 8'($urandom_range(0, 255));
        end
      endcase
      settle();
      write_reg(CfgFrameOffset, f_data);
      write_reg(CfgHaltOnStop,  h_data);
      write_reg(CfgStopSymbol,  s_data);
      phase_first = bases_taken;
      while (bases_taken - phase_first < PhaseBases) begin
        // Ragged lengths leave partial codons behind on purpose.
        seq_len = $urandom_range(1, 48);
        for (k = 0; k < seq_len; k++) begin
          r.data  = pick_base();
          r.start = (k == 0);
          offer_base(r);
        end
      end
    end

    settle();
    repeat (8) @(negedge clk_i);
    $display("Ran %0d bases through %0d register writes: %0d amino acids, %0d stop codons.",
             bases_taken, reg_writes, aminos_seen, stops_seen);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
